// ----- rtl/bqlp_pkg.sv -----
// Shared widths, constants, tables and stage payload types for the biquad lowpass coefficient pipeline.
package bqlp_pkg;

    localparam int COEF_FRAC_BITS = 30;
    localparam int TAN_ITERATIONS = 24;

    localparam int FS_W        = 18;
    localparam int FC_W        = 17;
    localparam int Q_W         = 16;
    localparam int COEF_W      = 32;
    localparam int U_FRAC_BITS = 32;
    localparam int ANGLE_W     = 31;
    localparam int Z_W         = 33;
    localparam int XY_W        = 32;
    localparam int XS_W        = XY_W - 4;
    localparam int PROD_W      = 2 * XS_W;
    localparam int TQ_W        = PROD_W - 1 + 8;
    localparam int DEN_W       = 64;
    localparam int NUM_LANES   = 4;
    localparam int QB          = COEF_W;
    localparam int INT_BITS    = COEF_W - COEF_FRAC_BITS;
    localparam int DIV_W       = DEN_W + INT_BITS;

    localparam int IN_TDATA_W  = ((FC_W + Q_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 5 * COEF_W;

    localparam int LANE_B0 = 0;
    localparam int LANE_B1 = 1;
    localparam int LANE_A1 = 2;
    localparam int LANE_A2 = 3;

    localparam logic [FS_W-1:0]    FS_RESET    = 18'd48000;
    localparam logic [FS_W-1:0]    FS_MIN      = 18'd2;
    localparam logic [Q_W-1:0]     Q_MIN       = 16'd26;
    localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [29:0] ATAN_TAB [0:31] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
    };

    typedef struct packed {
        logic [Q_W-1:0]        q;
        logic signed [Z_W-1:0] theta;
    } bqlp_angle_t;

    typedef struct packed {
        logic [Q_W-1:0]         q;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } bqlp_vec_t;

    typedef struct packed {
        logic [DEN_W-2:0]                  den;
        logic [NUM_LANES-1:0][DEN_W-1:0]   num;
    } bqlp_ratio_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][COEF_W-1:0]  coef;
        logic                              saturated;
    } bqlp_result_t;

endpackage

// ----- rtl/bqlp_phase.sv -----
// Cutoff and Q clamping, 2*fc/fs fraction by restoring division, and scaling to a Q2.30 angle.
module bqlp_phase
    import bqlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [FC_W-1:0]   cutoff_freq,
    input  logic [Q_W-1:0]    q_value,
    input  logic [FS_W-1:0]   sample_rate_hz,
    output logic              out_valid,
    output bqlp_angle_t       out
);

    logic [FS_W-1:0] fs_c;
    logic [FS_W-1:0] two_fc_c;
    logic [Q_W-1:0]  q_c;
    logic            ip_c;

    logic [FS_W-1:0]        fs_reg [0:U_FRAC_BITS];
    logic [FS_W-1:0]        r_reg  [0:U_FRAC_BITS];
    logic [U_FRAC_BITS-1:0] u_reg  [0:U_FRAC_BITS];
    logic                   ip_reg [0:U_FRAC_BITS];
    logic [Q_W-1:0]         q_reg  [0:U_FRAC_BITS];
    logic [U_FRAC_BITS:0]   v_reg;

    logic [U_FRAC_BITS+ANGLE_W-1:0] prod;
    logic [ANGLE_W-1:0]             theta_next;
    bqlp_angle_t                    out_reg;
    logic                           out_valid_reg;

    always_comb
    begin
        fs_c     = (sample_rate_hz < FS_MIN) ? FS_MIN : sample_rate_hz;
        two_fc_c = {cutoff_freq, 1'b0};
        if (two_fc_c < FS_MIN)
        begin
            two_fc_c = FS_MIN;
        end
        if (two_fc_c > fs_c)
        begin
            two_fc_c = fs_c;
        end
        q_c  = (q_value < Q_MIN) ? Q_MIN : q_value;
        ip_c = (two_fc_c == fs_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fs_reg[0] <= fs_c;
            ip_reg[0] <= ip_c;
            r_reg[0]  <= ip_c ? '0 : two_fc_c;
            u_reg[0]  <= '0;
            q_reg[0]  <= q_c;
        end
    end

    for (genvar k = 0; k < U_FRAC_BITS; k++)
    begin : g_frac
        logic [FS_W:0] rs;
        logic [FS_W:0] diff;
        logic          ge;

        assign rs   = {r_reg[k], 1'b0};
        assign ge   = rs >= {1'b0, fs_reg[k]};
        assign diff = rs - {1'b0, fs_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]  <= ge ? diff[FS_W-1:0] : rs[FS_W-1:0];
                u_reg[k+1]  <= {u_reg[k][U_FRAC_BITS-2:0], ge};
                fs_reg[k+1] <= fs_reg[k];
                ip_reg[k+1] <= ip_reg[k];
                q_reg[k+1]  <= q_reg[k];
            end
        end
    end

    // full-scale fraction only occurs at Nyquist, where the angle is exactly pi/2
    assign prod = (U_FRAC_BITS+ANGLE_W)'(u_reg[U_FRAC_BITS])
                * (U_FRAC_BITS+ANGLE_W)'(HALF_PI_Q30);
    assign theta_next = ip_reg[U_FRAC_BITS] ? HALF_PI_Q30
                                            : prod[U_FRAC_BITS+ANGLE_W-1:U_FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.q     <= q_reg[U_FRAC_BITS];
            out_reg.theta <= $signed(Z_W'(theta_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[U_FRAC_BITS-1:0], in_valid};
            out_valid_reg <= v_reg[U_FRAC_BITS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

// ----- rtl/bqlp_cordic.sv -----
// Rotation-mode CORDIC, one iteration per register stage, gain left uncorrected.
module bqlp_cordic
    import bqlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  bqlp_angle_t in,
    output logic        out_valid,
    output bqlp_vec_t   out
);

    localparam int N = TAN_ITERATIONS;

    logic signed [XY_W-1:0] x_reg [0:N-1];
    logic signed [XY_W-1:0] y_reg [0:N-1];
    logic signed [Z_W-1:0]  z_reg [0:N-1];
    logic [Q_W-1:0]         q_reg [0:N-1];
    logic [N-1:0]           v_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [XY_W-1:0] xp;
        logic signed [XY_W-1:0] yp;
        logic signed [Z_W-1:0]  zp;
        logic [Q_W-1:0]         qp;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  at;

        if (i == 0)
        begin : g_src_in
            assign xp = XY_W'(32'sh4000_0000);
            assign yp = '0;
            assign zp = in.theta;
            assign qp = in.q;
        end
        else
        begin : g_src_reg
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign qp = q_reg[i-1];
        end

        assign dx = yp >>> i;
        assign dy = xp >>> i;
        assign at = $signed(Z_W'(ATAN_TAB[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zp[Z_W-1])
                begin
                    x_reg[i] <= xp - dx;
                    y_reg[i] <= yp + dy;
                    z_reg[i] <= zp - at;
                end
                else
                begin
                    x_reg[i] <= xp + dx;
                    y_reg[i] <= yp - dy;
                    z_reg[i] <= zp + at;
                end
                q_reg[i] <= qp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            if (N > 1)
            begin
                v_reg <= {v_reg[N-2:0], in_valid};
            end
            else
            begin
                v_reg <= N'(in_valid);
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out.x     = x_reg[N-1];
    assign out.y     = y_reg[N-1];
    assign out.q     = q_reg[N-1];

endmodule

// ----- rtl/bqlp_ratio.sv -----
// Squares and cross term, x*y/Q by pipelined long division, then denominator and numerators.
module bqlp_ratio
    import bqlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  bqlp_vec_t   in,
    output logic        out_valid,
    output bqlp_ratio_t out
);

    logic signed [XS_W-1:0]   xs;
    logic signed [XS_W-1:0]   ys;
    logic signed [PROD_W-1:0] xx_reg;
    logic signed [PROD_W-1:0] yy_reg;
    logic signed [PROD_W-1:0] xy_reg;
    logic [Q_W-1:0]           qa_reg;
    logic                     va_reg;

    logic [TQ_W-1:0]         dvd_reg [0:TQ_W-1];
    logic [TQ_W-1:0]         quo_reg [0:TQ_W-1];
    logic [Q_W-1:0]          rem_reg [0:TQ_W-1];
    logic [Q_W-1:0]          q_reg   [0:TQ_W-1];
    logic                    neg_reg [0:TQ_W-1];
    logic signed [DEN_W-1:0] s2_reg  [0:TQ_W-1];
    logic signed [DEN_W-1:0] yy2_reg [0:TQ_W-1];
    logic signed [DEN_W-1:0] a1_reg  [0:TQ_W-1];
    logic [TQ_W-1:0]         v_reg;

    logic [PROD_W-1:0]       xy_mag;
    logic signed [DEN_W-1:0] qe;
    logic signed [DEN_W-1:0] den_c;
    logic signed [DEN_W-1:0] a2_c;
    bqlp_ratio_t             out_reg;
    logic                    out_valid_reg;

    assign xs = in.x[XY_W-1:4];
    assign ys = in.y[XY_W-1:4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= xs * xs;
            yy_reg <= ys * ys;
            xy_reg <= xs * ys;
            qa_reg <= in.q;
        end
    end

    assign xy_mag = xy_reg[PROD_W-1] ? PROD_W'(-xy_reg) : PROD_W'(xy_reg);

    for (genvar k = 0; k < TQ_W; k++)
    begin : g_div
        logic [TQ_W-1:0]         dvd_p;
        logic [TQ_W-1:0]         quo_p;
        logic [Q_W-1:0]          rem_p;
        logic [Q_W-1:0]          q_p;
        logic [Q_W:0]            rs;
        logic [Q_W:0]            diff;
        logic                    ge;

        if (k == 0)
        begin : g_src_a
            assign dvd_p = {xy_mag[PROD_W-2:0], 8'b0};
            assign quo_p = '0;
            assign rem_p = '0;
            assign q_p   = qa_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[0] <= xy_reg[PROD_W-1];
                    s2_reg[0]  <= DEN_W'(xx_reg) + DEN_W'(yy_reg);
                    yy2_reg[0] <= DEN_W'(yy_reg);
                    a1_reg[0]  <= (DEN_W'(yy_reg) - DEN_W'(xx_reg)) <<< 1;
                end
            end
        end
        else
        begin : g_src_reg
            assign dvd_p = dvd_reg[k-1];
            assign quo_p = quo_reg[k-1];
            assign rem_p = rem_reg[k-1];
            assign q_p   = q_reg[k-1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[k] <= neg_reg[k-1];
                    s2_reg[k]  <= s2_reg[k-1];
                    yy2_reg[k] <= yy2_reg[k-1];
                    a1_reg[k]  <= a1_reg[k-1];
                end
            end
        end

        assign rs   = {rem_p, dvd_p[TQ_W-1]};
        assign ge   = rs >= {1'b0, q_p};
        assign diff = rs - {1'b0, q_p};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[Q_W-1:0] : rs[Q_W-1:0];
                dvd_reg[k] <= {dvd_p[TQ_W-2:0], 1'b0};
                quo_reg[k] <= {quo_p[TQ_W-2:0], ge};
                q_reg[k]   <= q_p;
            end
        end
    end

    assign qe    = $signed(DEN_W'(quo_reg[TQ_W-1]));
    assign den_c = neg_reg[TQ_W-1] ? s2_reg[TQ_W-1] - qe : s2_reg[TQ_W-1] + qe;
    assign a2_c  = neg_reg[TQ_W-1] ? s2_reg[TQ_W-1] + qe : s2_reg[TQ_W-1] - qe;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.den          <= (den_c <= 0) ? (DEN_W-1)'(1) : den_c[DEN_W-2:0];
            out_reg.num[LANE_B0] <= yy2_reg[TQ_W-1];
            out_reg.num[LANE_B1] <= yy2_reg[TQ_W-1] <<< 1;
            out_reg.num[LANE_A1] <= a1_reg[TQ_W-1];
            out_reg.num[LANE_A2] <= a2_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg        <= in_valid;
            v_reg         <= {v_reg[TQ_W-2:0], va_reg};
            out_valid_reg <= v_reg[TQ_W-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

// ----- rtl/bqlp_coef.sv -----
// Four parallel fractional dividers num*2^F/den with overflow cap, sign and Q2.30 saturation.
module bqlp_coef
    import bqlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  bqlp_ratio_t  in,
    output logic         out_valid,
    output bqlp_result_t out
);

    localparam logic [COEF_W-1:0] MAG_CAP = COEF_W'(1) << (COEF_W - 1);
    localparam logic [COEF_W-1:0] POS_MAX = ~MAG_CAP;

    logic [DIV_W-1:0]     d_reg [0:QB];
    logic [QB:0]          v_reg;
    logic [NUM_LANES-1:0] sat_c;
    bqlp_result_t         out_reg;
    logic                 out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= DIV_W'(in.den);
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_den
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j+1] <= d_reg[j];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic [DIV_W-1:0]  r_reg   [0:QB];
        logic [COEF_W-1:0] qv_reg  [0:QB];
        logic              cap_reg [0:QB];
        logic              neg_reg [0:QB];
        logic [DEN_W-1:0]  num_mag;
        logic [DIV_W-1:0]  cap_lim;
        logic [COEF_W-1:0] mag;

        assign num_mag = in.num[l][DEN_W-1] ? DEN_W'(-in.num[l]) : in.num[l];
        assign cap_lim = (DIV_W'(in.den) << (INT_BITS - 1)) + DIV_W'(in.den);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[0]   <= DIV_W'(num_mag);
                qv_reg[0]  <= '0;
                cap_reg[0] <= DIV_W'(num_mag) >= cap_lim;
                neg_reg[0] <= in.num[l][DEN_W-1];
            end
        end

        for (genvar j = 0; j < QB; j++)
        begin : g_step
            logic [DIV_W-1:0] rs;
            logic [DIV_W-1:0] dv;
            logic             ge;

            if (j < INT_BITS)
            begin : g_int
                assign rs = r_reg[j];
                assign dv = d_reg[j] << (INT_BITS - 1 - j);
            end
            else
            begin : g_fr
                assign rs = r_reg[j] << 1;
                assign dv = d_reg[j];
            end

            assign ge = rs >= dv;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j+1]   <= ge ? rs - dv : rs;
                    qv_reg[j+1]  <= {qv_reg[j][COEF_W-2:0], ge};
                    cap_reg[j+1] <= cap_reg[j];
                    neg_reg[j+1] <= neg_reg[j];
                end
            end
        end

        assign mag = cap_reg[QB] ? MAG_CAP : qv_reg[QB];

        always_comb
        begin
            if (!neg_reg[QB])
            begin
                sat_c[l] = mag[COEF_W-1];
            end
            else
            begin
                sat_c[l] = mag > MAG_CAP;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!neg_reg[QB])
                begin
                    out_reg.coef[l] <= mag[COEF_W-1] ? POS_MAX : mag;
                end
                else
                begin
                    out_reg.coef[l] <= (mag > MAG_CAP) ? MAG_CAP : COEF_W'(-mag);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.saturated <= |sat_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QB-1:0], in_valid};
            out_valid_reg <= v_reg[QB];
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

// ----- rtl/biquad_lowpass_coefficient_calc_core.sv -----
// One item per cycle sustained while the skid entry is empty.
// The pipeline is 157 register stages (34 phase, TAN_ITERATIONS CORDIC, 65 cross-term
// division, 34 coefficient division) plus an output register and one skid entry.
// The whole pipeline holds while the skid entry is full; s_tready is its empty flag.
// rst_n is asynchronous, active low: clears all valid bits, sample rate returns to 48000.
module biquad_lowpass_coefficient_calc_core
    import bqlp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // cutoff_freq[16:0], q_value[32:17], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // coef_b0, coef_b1, coef_b2, coef_a1, coef_a2
    output logic [0:0]             m_tuser,   // saturated
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [FS_W-1:0]        cfg_data
);

    logic [FS_W-1:0] fs_reg;
    logic            pipe_en;

    logic         ph_valid;
    bqlp_angle_t  ph_out;
    logic         cd_valid;
    bqlp_vec_t    cd_out;
    logic         rt_valid;
    bqlp_ratio_t  rt_out;
    logic         cf_valid;
    bqlp_result_t cf_out;

    bqlp_result_t out_reg;
    logic         out_valid_reg;
    bqlp_result_t skid_reg;
    logic         skid_valid_reg;
    logic         pop;
    logic         push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
        end
        else if (cfg_valid)
        begin
            fs_reg <= cfg_data;
        end
    end

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    bqlp_phase u_phase (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (pipe_en),
        .in_valid       (s_tvalid),
        .cutoff_freq    (s_tdata[FC_W-1:0]),
        .q_value        (s_tdata[FC_W+Q_W-1:FC_W]),
        .sample_rate_hz (fs_reg),
        .out_valid      (ph_valid),
        .out            (ph_out)
    );

    bqlp_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (ph_valid),
        .in        (ph_out),
        .out_valid (cd_valid),
        .out       (cd_out)
    );

    bqlp_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (cd_valid),
        .in        (cd_out),
        .out_valid (rt_valid),
        .out       (rt_out)
    );

    bqlp_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (rt_valid),
        .in        (rt_out),
        .out_valid (cf_valid),
        .out       (cf_out)
    );

    assign pop  = out_valid_reg && m_tready;
    assign push = pipe_en && cf_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= cf_out;
            end
            else
            begin
                out_reg <= cf_out;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.coef[LANE_A2], out_reg.coef[LANE_A1], out_reg.coef[LANE_B0],
                       out_reg.coef[LANE_B1], out_reg.coef[LANE_B0]};
    assign m_tuser  = out_reg.saturated;

endmodule

// ----- dv/tb_biquad_lowpass_coefficient_calc_core.sv -----
// Testbench for the biquad lowpass coefficient pipeline: directed table, random items, self-checking.
module tb_biquad_lowpass_coefficient_calc_core;
    import bqlp_pkg::*;

    typedef struct {
        logic [31:0] b0, b1, b2, a1, a2;
        logic        sat;
    } coef_set_t;

    typedef struct {
        logic [FC_W-1:0] fc;
        logic [Q_W-1:0]  q;
        bit              known;
        coef_set_t       res;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [FS_W-1:0]        cfg_data;

    coef_set_t     coef_queue[$];
    logic [17:0]   fs_model;
    int            idle_pct;
    int            stall_pct;
    bit            hold_go;
    int            n_err;

    biquad_lowpass_coefficient_calc_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned ratio_q30(longint unsigned n, longint unsigned d);
        longint unsigned ip, r, qv;
        ip = n / d;
        r = n % d;
        if (ip > ((64'd1 << 31) >> COEF_FRAC_BITS))
            return 64'd1 << 31;
        qv = ip;
        for (int i = 0; i < COEF_FRAC_BITS; i++)
        begin
            r = r << 1;
            qv = qv << 1;
            if (r >= d)
            begin
                r = r - d;
                qv = qv | 64'd1;
            end
        end
        return qv;
    endfunction

    function automatic logic [31:0] clip_coef(longint num, longint den, ref logic sat);
        longint unsigned mag;
        longint v;
        mag = ratio_q30(num < 0 ? longint'(-num) : num, den);
        v = num < 0 ? -longint'(mag) : longint'(mag);
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
            sat = 1'b1;
        end
        else if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
            sat = 1'b1;
        end
        return v[31:0];
    endfunction

    function automatic coef_set_t lowpass_coefs(logic [17:0] fs_reg, logic [FC_W-1:0] fc,
                                                logic [Q_W-1:0] qin);
        coef_set_t r;
        longint unsigned fs, two_fc, q, u;
        longint x, y, z, dx, dy, xs, ys, yy, s2, t, den;
        logic sat;
        sat = 1'b0;
        fs = 64'(fs_reg);
        two_fc = 64'(fc) * 2;
        q = 64'(qin);
        if (fs < 2) fs = 2;
        if (two_fc < 2) two_fc = 2;
        if (two_fc > fs) two_fc = fs;
        if (q < 26) q = 26;
        u = (two_fc << 32) / fs;
        z = longint'((u * 64'd1686629713) >> 32);
        x = 64'sd1 << 30;
        y = 0;
        for (int i = 0; i < TAN_ITERATIONS && i < 32; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
        end
        xs = floor_shift(x, 4);
        ys = floor_shift(y, 4);
        yy = ys * ys;
        s2 = xs * xs + yy;
        t = (xs * ys * 256) / longint'(q);
        den = s2 + t;
        if (den <= 0) den = 1;
        r.b0 = clip_coef(yy, den, sat);
        r.b1 = clip_coef(2 * yy, den, sat);
        r.b2 = r.b0;
        r.a1 = clip_coef(2 * (yy - xs * xs), den, sat);
        r.a2 = clip_coef(s2 - t, den, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic send_item(logic [FC_W-1:0] fc, logic [Q_W-1:0] q, bit known, coef_set_t res);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({q, fc});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        coef_queue.push_back(known ? res : lowpass_coefs(fs_model, fc, q));
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (coef_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_fs(logic [17:0] v);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        fs_model = v;
    endtask

    task automatic random_block(int n);
        coef_set_t dummy;
        logic [FC_W-1:0] fc;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(3))
                0: fc = FC_W'($urandom);
                1: fc = FC_W'($urandom_range(20000));
                2: fc = FC_W'((fs_model >> 1) + $urandom_range(4) - 2);
                default: fc = FC_W'($urandom_range(100));
            endcase
            send_item(fc, ($urandom_range(3) == 0) ? Q_W'($urandom_range(40)) : Q_W'($urandom),
                      1'b0, dummy);
        end
    endtask

    // receiver ready, with one long hold counted here
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        coef_set_t e;
        if (m_tvalid && m_tready)
        begin
            if (coef_queue.size() == 0)
            begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", m_tdata);
            end
            else
            begin
                e = coef_queue.pop_front();
                if (m_tdata !== {e.a2, e.a1, e.b2, e.b1, e.b0} || m_tuser[0] !== e.sat)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp %h/%b got %h/%b",
                                 {e.a2, e.a1, e.b2, e.b1, e.b0}, e.sat, m_tdata, m_tuser[0]);
                end
            end
        end
    end

    initial
    begin
        #200000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        coef_set_t none;
        none = '{default: '0};
        s_tvalid = 1'b0; s_tdata = '0;
        cfg_valid = 1'b0; cfg_data = '0;
        idle_pct = 0; stall_pct = 0; hold_go = 1'b0; n_err = 0;
        fs_model = 18'd48000;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clamps, extremes, Nyquist saturation
        rows.push_back('{17'd24000, 16'd256, 1'b0, none});
        rows.push_back('{17'd0, 16'd0, 1'b0, none});
        rows.push_back('{17'd1, 16'd25, 1'b0, none});
        rows.push_back('{17'd1, 16'd26, 1'b0, none});
        rows.push_back('{17'd131071, 16'hffff, 1'b0, none});
        rows.push_back('{17'd131071, 16'd0, 1'b0, none});
        rows.push_back('{17'd1000, 16'd181, 1'b0, none});
        rows.push_back('{17'd12000, 16'd256, 1'b0, none});
        rows.push_back('{17'd23999, 16'd256, 1'b0, none});
        rows.push_back('{17'd0, 16'hffff, 1'b0, none});
        rows.push_back('{17'h15555, 16'haaaa, 1'b0, none});
        rows.push_back('{17'h0aaaa, 16'h5555, 1'b0, none});
        foreach (rows[i])
            send_item(rows[i].fc, rows[i].q, rows[i].known, rows[i].res);

        write_fs(18'd8000);
        random_block(150);
        write_fs(18'd192000);
        random_block(150);
        write_fs(18'd44101);
        send_item(17'd22051, 16'd256, 1'b0, none);
        write_fs(18'd0);
        random_block(30);
        write_fs(18'h3ffff);
        random_block(60);
        write_fs(18'd48000);

        idle_pct = 0; stall_pct = 0;
        random_block(300);
        idle_pct = 62; stall_pct = 0;
        random_block(250);
        idle_pct = 0; stall_pct = 62;
        random_block(250);
        idle_pct = 25; stall_pct = 25;
        random_block(200);
        drain_pipe();
        idle_pct = 0; stall_pct = 0;
        hold_go = 1'b1;
        random_block(300);
        write_fs(18'd96000);
        random_block(60);

        drain_pipe();
        fork
            begin
                repeat (200000) @(posedge clk);
            end
            begin
                while (coef_queue.size() != 0) @(posedge clk);
                repeat (200) @(posedge clk);
            end
        join_any
        if (n_err == 0 && coef_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
